// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- design/mrsc_pkg.sv -----
`timescale 1ns / 1ps

package mrsc_pkg;

    // Field widths
    localparam int unsigned ACT_W = 3;
    localparam int unsigned QW    = 3;
    localparam int unsigned SW    = 6;
    localparam int unsigned CNT_W = 4;
    localparam int unsigned LG_W  = 3;

    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 16;
    localparam int unsigned CFG_DATA_W  = 8;

    // Default geometry
    localparam int unsigned QUEUES_DEF = 8;
    localparam int unsigned SLOTS_DEF  = 64;

    // Command queue between front and back
    localparam int unsigned FIFO_DEPTH = 2;

    // Register reset values
    localparam logic [CNT_W-1:0] QUEUES_IN_USE_RST  = 4'd8;
    localparam logic [LG_W-1:0]  RING_SIZE_LOG2_RST = 3'd6;

    // Register indexes
    localparam logic CFG_QUEUES_IN_USE  = 1'b0;
    localparam logic CFG_RING_SIZE_LOG2 = 1'b1;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_PRODUCE_ONE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PRODUCE_ANY = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CONSUME_ONE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CONSUME_ANY = 3'd3;
    localparam logic [ACT_W-1:0] ACT_MARK_FULL   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_MARK_IDLE   = 3'd5;

    typedef enum logic [1:0] {
        K_NONE      = 2'd0,
        K_CLAIM_ONE = 2'd1,
        K_CLAIM_ANY = 2'd2,
        K_MARK      = 2'd3
    } kind_t;

    typedef struct packed {
        logic [CNT_W-1:0] queues_in_use;
        logic [LG_W-1:0]  ring_size_log2;
    } cfg_t;

    // want_full: consume side for claims, flag value for marks
    typedef struct packed {
        kind_t           kind;
        logic            want_full;
        logic [QW-1:0]   queue;
        logic [SW-1:0]   slot;
    } cmd_t;

    // Queue count clipped to the rings that exist
    function automatic logic [CNT_W-1:0] active_queues(logic [CNT_W-1:0] qiu,
                                                       int unsigned queues);
        logic [CNT_W-1:0] n;
        n = qiu;
        if (32'(qiu) > queues) n = CNT_W'(queues);
        return n;
    endfunction

    // Ring size exponent clipped to what the slot store holds
    function automatic logic [LG_W-1:0] eff_lg(logic [LG_W-1:0] lg, int unsigned cap);
        logic [LG_W-1:0] r;
        r = lg;
        if (32'(lg) > cap) r = LG_W'(cap);
        return r;
    endfunction

endpackage

// ----- design/mrsc_front.sv -----
`timescale 1ns / 1ps

module mrsc_front #(
    parameter int unsigned QUEUES = mrsc_pkg::QUEUES_DEF,
    parameter int unsigned SLOTS  = mrsc_pkg::SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // config write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_index,
    input  logic [mrsc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mrsc_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [mrsc_pkg::ACT_W-1:0]       s_tuser,
    // to command queue and back end
    output mrsc_pkg::cfg_t                   cfg,
    output logic                             push,
    output mrsc_pkg::cmd_t                   cmd,
    input  logic                             fifo_full,
    input  logic                             clear_busy
);

    localparam int unsigned LG_CAP0 = $clog2(SLOTS + 1) - 1;
    localparam int unsigned LG_MAX  = (1 << mrsc_pkg::LG_W) - 1;
    localparam int unsigned LG_CAP  = (LG_CAP0 > LG_MAX) ? LG_MAX : LG_CAP0;

    logic [mrsc_pkg::CNT_W-1:0] qiu_reg;
    logic [mrsc_pkg::LG_W-1:0]  lg_reg;

    logic [mrsc_pkg::ACT_W-1:0] act;
    logic [mrsc_pkg::QW-1:0]    q;
    logic [mrsc_pkg::SW-1:0]    s;
    logic [mrsc_pkg::CNT_W-1:0] n_act;
    logic [mrsc_pkg::LG_W-1:0]  lg_eff;
    logic                       q_ok;
    logic                       s_ok;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qiu_reg <= mrsc_pkg::QUEUES_IN_USE_RST;
            lg_reg  <= mrsc_pkg::RING_SIZE_LOG2_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mrsc_pkg::CFG_QUEUES_IN_USE:  qiu_reg <= cfg_wdata[mrsc_pkg::CNT_W-1:0];
                mrsc_pkg::CFG_RING_SIZE_LOG2: lg_reg  <= cfg_wdata[mrsc_pkg::LG_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.queues_in_use  = qiu_reg;
    assign cfg.ring_size_log2 = lg_reg;

    // Accept while the queue has room and the flag store is ready
    assign s_tready = !fifo_full && !clear_busy;
    assign push     = s_tvalid && s_tready;

    assign act    = s_tuser;
    assign q      = s_tdata[mrsc_pkg::QW-1:0];
    assign s      = s_tdata[mrsc_pkg::QW +: mrsc_pkg::SW];
    assign n_act  = mrsc_pkg::active_queues(qiu_reg, QUEUES);
    assign lg_eff = mrsc_pkg::eff_lg(lg_reg, LG_CAP);
    assign q_ok   = {1'b0, q} < n_act;
    assign s_ok   = (s >> lg_eff) == '0;

    // Classify: a bad queue, or a bad slot on a mark, turns into a no-op
    always_comb begin
        cmd.kind      = mrsc_pkg::K_NONE;
        cmd.want_full = 1'b0;
        cmd.queue     = q;
        cmd.slot      = s;
        unique case (act)
            mrsc_pkg::ACT_PRODUCE_ONE: begin
                if (q_ok) cmd.kind = mrsc_pkg::K_CLAIM_ONE;
            end
            mrsc_pkg::ACT_CONSUME_ONE: begin
                if (q_ok) cmd.kind = mrsc_pkg::K_CLAIM_ONE;
                cmd.want_full = 1'b1;
            end
            mrsc_pkg::ACT_PRODUCE_ANY: begin
                cmd.kind = mrsc_pkg::K_CLAIM_ANY;
            end
            mrsc_pkg::ACT_CONSUME_ANY: begin
                cmd.kind      = mrsc_pkg::K_CLAIM_ANY;
                cmd.want_full = 1'b1;
            end
            mrsc_pkg::ACT_MARK_FULL: begin
                if (q_ok && s_ok) cmd.kind = mrsc_pkg::K_MARK;
                cmd.want_full = 1'b1;
            end
            mrsc_pkg::ACT_MARK_IDLE: begin
                if (q_ok && s_ok) cmd.kind = mrsc_pkg::K_MARK;
            end
            default: ;
        endcase
    end

endmodule

// ----- design/mrsc_cmd_fifo.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mrsc_cmd_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  mrsc_pkg::cmd_t  din,
    output logic            full,
    input  logic            pop,
    output mrsc_pkg::cmd_t  dout,
    output logic            empty
);

    localparam int unsigned DEPTH = mrsc_pkg::FIFO_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mrsc_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push) count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entries hold no reset
    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= din;
    end

    `ASSERT_ALWAYS(a_no_pop_empty, aclk, aresetn, !(pop && empty), "pop from empty command queue")

endmodule

// ----- design/mrsc_back.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mrsc_back #(
    parameter int unsigned QUEUES = mrsc_pkg::QUEUES_DEF,
    parameter int unsigned SLOTS  = mrsc_pkg::SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mrsc_pkg::cfg_t                   cfg,
    input  mrsc_pkg::cmd_t                   head,
    input  logic                             empty,
    output logic                             pop,
    output logic                             clear_busy,
    // result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mrsc_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [0:0]                       m_tuser
);

    localparam int unsigned DEPTH   = QUEUES * SLOTS;
    localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned QIW     = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int unsigned LG_CAP0 = $clog2(SLOTS + 1) - 1;
    localparam int unsigned LG_MAX  = (1 << mrsc_pkg::LG_W) - 1;
    localparam int unsigned LG_CAP  = (LG_CAP0 > LG_MAX) ? LG_MAX : LG_CAP0;
    localparam int unsigned PW      = (LG_CAP > 0) ? LG_CAP : 1;
    localparam int unsigned PAD_W   = mrsc_pkg::OUT_TDATA_W - mrsc_pkg::QW - mrsc_pkg::SW;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_ISSUE = 5'b00100,
        S_CHECK = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [AW-1:0]              clr_cnt_reg, clr_cnt_next;
    logic [mrsc_pkg::CNT_W-1:0] cur_q_reg, cur_q_next;
    logic [PW-1:0]              ptr_sel_reg, ptr_sel_next;
    logic                       res_granted_reg, res_granted_next;
    logic [mrsc_pkg::QW-1:0]    res_queue_reg, res_queue_next;
    logic [mrsc_pkg::SW-1:0]    res_slot_reg, res_slot_next;

    logic                       m_tvalid_reg;
    logic                       m_granted_reg;
    logic [mrsc_pkg::QW-1:0]    m_queue_reg;
    logic [mrsc_pkg::SW-1:0]    m_slot_reg;

    logic [PW-1:0]              prod_ptr_reg [QUEUES];
    logic [PW-1:0]              cons_ptr_reg [QUEUES];

    logic                       flag_mem [DEPTH];
    logic                       rd_data_reg;

    logic [mrsc_pkg::CNT_W-1:0] n_act;
    logic [mrsc_pkg::LG_W-1:0]  lg_eff;
    logic [PW-1:0]              mask;
    logic [mrsc_pkg::CNT_W-1:0] probe_q;
    logic [PW-1:0]              probe_ptr;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic                       wr_data;
    logic                       hit;
    logic                       ptr_upd_en;
    logic [PW-1:0]              ptr_inc;
    logic                       out_free;

    assign n_act    = mrsc_pkg::active_queues(cfg.queues_in_use, QUEUES);
    assign lg_eff   = mrsc_pkg::eff_lg(cfg.ring_size_log2, LG_CAP);
    assign mask     = PW'((32'd1 << lg_eff) - 32'd1);
    assign out_free = !m_tvalid_reg || m_tready;
    assign clear_busy = state_reg == S_CLEAR;

    // Probe address: the queue under test, or the next one down while checking
    assign probe_q   = (state_reg == S_CHECK && cur_q_reg != '0) ? cur_q_reg - 1'b1
                                                                  : cur_q_reg;
    assign probe_ptr = (head.want_full ? cons_ptr_reg[QIW'(probe_q)]
                                       : prod_ptr_reg[QIW'(probe_q)]) & mask;
    assign rd_addr   = AW'(probe_q) * AW'(SLOTS) + AW'(probe_ptr);
    assign hit       = rd_data_reg == head.want_full;
    assign ptr_inc   = (ptr_sel_reg + PW'(1)) & mask;

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        cur_q_next       = cur_q_reg;
        ptr_sel_next     = ptr_sel_reg;
        res_granted_next = res_granted_reg;
        res_queue_next   = res_queue_reg;
        res_slot_next    = res_slot_reg;
        wr_en            = 1'b0;
        wr_addr          = rd_addr;
        wr_data          = 1'b0;
        ptr_upd_en       = 1'b0;
        pop              = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                if (clr_cnt_reg == AW'(DEPTH - 1)) state_next = S_IDLE;
                else clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            S_IDLE: begin
                if (!empty) begin
                    res_granted_next = 1'b0;
                    res_queue_next   = '0;
                    res_slot_next    = '0;
                    state_next       = S_RESP;
                    unique case (head.kind)
                        mrsc_pkg::K_CLAIM_ONE: begin
                            cur_q_next = {1'b0, head.queue};
                            state_next = S_ISSUE;
                        end
                        mrsc_pkg::K_CLAIM_ANY: begin
                            if (n_act != '0) begin
                                cur_q_next = n_act - 1'b1;
                                state_next = S_ISSUE;
                            end
                        end
                        mrsc_pkg::K_MARK: begin
                            wr_en            = 1'b1;
                            wr_addr          = AW'(head.queue) * AW'(SLOTS) + AW'(head.slot);
                            wr_data          = head.want_full;
                            res_granted_next = 1'b1;
                            res_queue_next   = head.queue;
                            res_slot_next    = head.slot;
                        end
                        default: ;
                    endcase
                end
            end
            S_ISSUE: begin
                ptr_sel_next = probe_ptr;
                state_next   = S_CHECK;
            end
            S_CHECK: begin
                // one probe per cycle; a miss issues the next queue's read
                if (hit) begin
                    ptr_upd_en       = 1'b1;
                    res_granted_next = 1'b1;
                    res_queue_next   = mrsc_pkg::QW'(cur_q_reg);
                    res_slot_next    = mrsc_pkg::SW'(ptr_sel_reg);
                    state_next       = S_RESP;
                end else if (head.kind == mrsc_pkg::K_CLAIM_ANY && cur_q_reg != '0) begin
                    cur_q_next   = probe_q;
                    ptr_sel_next = probe_ptr;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    pop        = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_q_reg       <= cur_q_next;
        ptr_sel_reg     <= ptr_sel_next;
        res_granted_reg <= res_granted_next;
        res_queue_reg   <= res_queue_next;
        res_slot_reg    <= res_slot_next;
    end

    // Ring pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < QUEUES; i++) begin
                prod_ptr_reg[i] <= '0;
                cons_ptr_reg[i] <= '0;
            end
        end else if (ptr_upd_en) begin
            if (head.want_full) cons_ptr_reg[QIW'(cur_q_reg)] <= ptr_inc;
            else prod_ptr_reg[QIW'(cur_q_reg)] <= ptr_inc;
        end
    end

    // Slot flag store, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) flag_mem[wr_addr] <= wr_data;
        rd_data_reg <= flag_mem[rd_addr];
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_RESP && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_RESP && out_free) begin
            m_granted_reg <= res_granted_reg;
            m_queue_reg   <= res_queue_reg;
            m_slot_reg    <= res_slot_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tuser[0] = m_granted_reg;
    assign m_tdata    = {{PAD_W{1'b0}}, m_slot_reg, m_queue_reg};

    `ASSERT_ALWAYS(a_clear_no_pop, aclk, aresetn, !(clear_busy && pop), "command taken during clear")
    `ASSERT_ALWAYS(a_resp_has_cmd, aclk, aresetn, !(state_reg == S_RESP && empty), "response without command")
    `ASSERT_NEXT(a_grant_slot_in_ring, aclk, aresetn, state_reg == S_CHECK && hit, (res_slot_reg >> lg_eff) == '0, "granted slot outside ring")

endmodule

// ----- design/multi_ring_slot_claim_engine_top.sv -----
`timescale 1ns / 1ps

// Slot claim engine for up to QUEUES single-producer single-consumer rings of
// up to SLOTS slots each. An input word carries the action in s_tuser and the
// queue and slot in s_tdata; every word returns exactly one result word, with
// the grant flag in m_tuser and the queue and slot in m_tdata. Words pass a
// two-entry command queue to a sequencer that owns the ring pointers and the
// slot flag memory. That memory has one read port, so a claim probes one queue
// per cycle: a single-queue claim probes only the queue it names, an any-queue
// claim probes queues from the highest active one down to queue 0 until one
// hits, and marks, rejected words and unknown actions go straight to the result.
// After reset all flag memory entries are cleared, during which s_tready stays
// low; configuration writes are taken at any time and must only be issued while
// no word is in flight.
module multi_ring_slot_claim_engine_top #(
    parameter int unsigned QUEUES = mrsc_pkg::QUEUES_DEF,
    parameter int unsigned SLOTS  = mrsc_pkg::SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // config: index 0 queues_in_use, index 1 ring_size_log2
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_index,
    input  logic [mrsc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mrsc_pkg::IN_TDATA_W-1:0]  s_tdata,   // [2:0] queue_index, [8:3] slot_index
    input  logic [mrsc_pkg::ACT_W-1:0]       s_tuser,   // [2:0] action
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mrsc_pkg::OUT_TDATA_W-1:0] m_tdata,   // [2:0] granted_queue, [8:3] granted_slot
    output logic [0:0]                       m_tuser    // [0] granted
);

    mrsc_pkg::cfg_t cfg;
    mrsc_pkg::cmd_t cmd_in;
    mrsc_pkg::cmd_t cmd_head;
    logic           push;
    logic           pop;
    logic           fifo_full;
    logic           fifo_empty;
    logic           clear_busy;

    mrsc_front #(
        .QUEUES (QUEUES),
        .SLOTS  (SLOTS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg        (cfg),
        .push       (push),
        .cmd        (cmd_in),
        .fifo_full  (fifo_full),
        .clear_busy (clear_busy)
    );

    mrsc_cmd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (cmd_in),
        .full    (fifo_full),
        .pop     (pop),
        .dout    (cmd_head),
        .empty   (fifo_empty)
    );

    mrsc_back #(
        .QUEUES (QUEUES),
        .SLOTS  (SLOTS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .head       (cmd_head),
        .empty      (fifo_empty),
        .pop        (pop),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
